// ----- design/plst_pkg.sv -----
`timescale 1ns / 1ps

package plst_pkg;

  // Storage shape
  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 7;
  localparam int CNT_OUT_W = 7;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // wide enough to compare position against count + 1 without wrap
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Readout tree: each level ORs up to TREE_FAN taps into one register
  localparam int TREE_FAN = 8;

  function automatic int tree_levels(input int n);
    int lvls;
    int span;
    lvls = 0;
    span = 1;
    while (span < n) begin
      span = span * TREE_FAN;
      lvls = lvls + 1;
    end
    return (lvls < 1) ? 1 : lvls;
  endfunction

  localparam int TREE_LVLS = tree_levels(CAPACITY);

  typedef logic [DATA_W-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_READ       = 3'd0,
    OP_WRITE      = 3'd1,
    OP_INS_FRONT  = 3'd2,
    OP_INS_END    = 3'd3,
    OP_INS_AT     = 3'd4,
    OP_REM_FRONT  = 3'd5,
    OP_REM_END    = 3'd6,
    OP_REM_AT     = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // What each cell does on the accepting edge
  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_DELETE = 2'd3
  } act_t;

  typedef struct packed {
    act_t             act;
    logic [IDX_W-1:0] tgt;
    logic [CNT_W-1:0] cnt;   // count before the operation
  } cell_ctl_t;

  // Which cells drive the readout trees
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             tail_en;
    logic [IDX_W-1:0] tail_idx;
  } sel_ctl_t;

endpackage

// ----- design/positional_list_store.sv -----
`timescale 1ns / 1ps

// Bounded ordered list of signed 32-bit words, addressed by 1-based position.
// Input channel (in_valid/in_ready): op, position, data_in. Ops: read, write,
// insert front/end/at, remove front/end/at. Output channel (out_valid/
// out_ready): one word per input with read data, status, count, empty flag,
// and head and tail values after the operation.
// Storage is a row of CAPACITY cells; on the accepting edge every cell
// compares its index with the target and loads, shifts or holds, so the list
// is updated in place on that edge. Read data and tail are then gathered by
// two registered OR trees, TREE_LVLS levels of 8 (2 levels at 64 entries).
// One word is handled at a time: no new input is accepted until the current
// word has passed the readout trees and reached the output register.
// in_ready is high whenever no word is in flight, including while a finished
// result waits in the output register; a stalled receiver holds the next
// result in the trees until out_ready, and blocks further input meanwhile.
// Reset (rst_n low, synchronous) empties the list and drops out_valid; cell
// contents are not cleared and are never read before being written.
module positional_list_store import plst_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          in_op,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_data_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_data_out,
  output logic [1:0]               out_status,
  output logic [CNT_OUT_W-1:0]     out_count,
  output logic                     out_is_empty,
  output logic signed [DATA_W-1:0] out_head_value,
  output logic signed [DATA_W-1:0] out_tail_value
);

  localparam int WAIT_W = $clog2(TREE_LVLS + 1) + 1;

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_t;

  state_t            state_r;
  logic [WAIT_W-1:0] wait_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  status_t           status_r;
  status_t           status_nxt;
  sel_ctl_t          sel_r;
  sel_ctl_t          sel_nxt;
  cell_ctl_t         ctl;
  cell_ctl_t         ctl_dec;

  logic              out_valid_r;
  word_t             out_data_r;
  status_t           out_status_r;
  logic [CNT_W-1:0]  out_count_r;
  logic              out_empty_r;
  word_t             out_head_r;
  word_t             out_tail_r;

  logic              in_acc;
  logic              done;
  logic [CMP_W-1:0]  pos_x;
  logic [CMP_W-1:0]  cnt_x;
  logic              is_empty;
  logic              is_full;
  logic              in_range;
  logic              ins_range;
  logic [IDX_W-1:0]  pos_idx;

  word_t             cell_q   [CAPACITY];
  word_t             rd_taps  [CAPACITY];
  word_t             tl_taps  [CAPACITY];
  word_t             rd_sel;
  word_t             tl_sel;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign done     = (state_r == S_BUSY) && (wait_r == WAIT_W'(TREE_LVLS)) &&
                    (!out_valid_r || out_ready);

  // Operation decode against the current length
  assign pos_x     = CMP_W'(in_position);
  assign cnt_x     = CMP_W'(count_r);
  assign is_empty  = (count_r == '0);
  assign is_full   = (count_r == CNT_W'(CAPACITY));
  assign in_range  = (pos_x != '0) && (pos_x <= cnt_x);
  assign ins_range = (pos_x != '0) && (pos_x <= cnt_x + 1'b1);
  assign pos_idx   = IDX_W'(pos_x - 1'b1);

  always_comb begin
    status_nxt  = ST_OK;
    count_nxt   = count_r;
    ctl_dec.act = ACT_HOLD;
    ctl_dec.tgt = pos_idx;
    ctl_dec.cnt = count_r;
    case (op_t'(in_op))
      OP_READ, OP_WRITE, OP_REM_AT: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else if (!in_range) begin
          status_nxt = ST_BADPOS;
        end else if (op_t'(in_op) == OP_WRITE) begin
          ctl_dec.act = ACT_WRITE;
        end else if (op_t'(in_op) == OP_REM_AT) begin
          ctl_dec.act = ACT_DELETE;
          count_nxt   = count_r - 1'b1;
        end
      end
      OP_INS_FRONT, OP_INS_END: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          ctl_dec.act = ACT_INSERT;
          ctl_dec.tgt = (op_t'(in_op) == OP_INS_FRONT) ? '0 : IDX_W'(count_r);
          count_nxt   = count_r + 1'b1;
        end
      end
      OP_INS_AT: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else if (!ins_range) begin
          status_nxt = ST_BADPOS;
        end else if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          ctl_dec.act = ACT_INSERT;
          count_nxt   = count_r + 1'b1;
        end
      end
      OP_REM_FRONT, OP_REM_END: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          if (op_t'(in_op) == OP_REM_FRONT) begin
            ctl_dec.act = ACT_DELETE;
            ctl_dec.tgt = '0;
          end
          count_nxt = count_r - 1'b1;
        end
      end
      default: status_nxt = ST_OK;
    endcase
  end

  // Readout selection for the trees, taken from the updated list
  always_comb begin
    sel_nxt.rd_en    = (op_t'(in_op) == OP_READ) && !is_empty && in_range;
    sel_nxt.rd_idx   = pos_idx;
    sel_nxt.tail_en  = (count_nxt != '0);
    sel_nxt.tail_idx = IDX_W'(count_nxt - 1'b1);
  end

  // Cells only move on the accepting edge
  always_comb begin
    ctl = ctl_dec;
    if (!in_acc) ctl.act = ACT_HOLD;
  end

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t left_w;
    word_t right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_q[i - 1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_q[i + 1];
    end

    plst_cell u_cell (
      .clk      (clk),
      .idx      (IDX_W'(i)),
      .ctl      (ctl),
      .sel      (sel_r),
      .din      (in_data_in),
      .left_q   (left_w),
      .right_q  (right_w),
      .q        (cell_q[i]),
      .rd_tap   (rd_taps[i]),
      .tail_tap (tl_taps[i])
    );
  end

  plst_sel_tree u_rd_tree (
    .clk   (clk),
    .taps  (rd_taps),
    .sel_q (rd_sel)
  );

  plst_sel_tree u_tail_tree (
    .clk   (clk),
    .taps  (tl_taps),
    .sel_q (tl_sel)
  );

  // Sequencer, list length and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new word replaces the one taken in the same cycle
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r  <= S_BUSY;
            wait_r   <= '0;
            count_r  <= count_nxt;
            status_r <= status_nxt;
            sel_r    <= sel_nxt;
          end
        end
        S_BUSY: begin
          if (wait_r != WAIT_W'(TREE_LVLS)) wait_r <= wait_r + 1'b1;
          if (done) begin
            state_r      <= S_IDLE;
            out_data_r   <= rd_sel;
            out_status_r <= status_r;
            out_count_r  <= count_r;
            out_empty_r  <= (count_r == '0);
            out_head_r   <= (count_r == '0) ? '0 : cell_q[0];
            out_tail_r   <= tl_sel;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_out   = out_data_r;
  assign out_status     = out_status_r;
  assign out_count      = CNT_OUT_W'(out_count_r);
  assign out_is_empty   = out_empty_r;
  assign out_head_value = out_head_r;
  assign out_tail_value = out_tail_r;

endmodule

// ----- design/plst_cell.sv -----
`timescale 1ns / 1ps

module plst_cell import plst_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  cell_ctl_t        ctl,
  input  sel_ctl_t         sel,
  input  word_t            din,
  input  word_t            left_q,
  input  word_t            right_q,
  output word_t            q,
  output word_t            rd_tap,
  output word_t            tail_tap
);

  word_t            q_r;
  word_t            q_nxt;
  logic [CNT_W-1:0] idx_x;

  assign idx_x = CNT_W'(idx);

  // Local update: hold, overwrite, take left neighbor (gap open) or right (gap close)
  always_comb begin
    q_nxt = q_r;
    case (ctl.act)
      ACT_WRITE: begin
        if (idx == ctl.tgt) q_nxt = din;
      end
      ACT_INSERT: begin
        if (idx == ctl.tgt) begin
          q_nxt = din;
        end else if (idx > ctl.tgt && idx_x <= ctl.cnt) begin
          q_nxt = left_q;
        end
      end
      ACT_DELETE: begin
        if (idx >= ctl.tgt && (idx_x + 1'b1) < ctl.cnt) q_nxt = right_q;
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q        = q_r;
  assign rd_tap   = (sel.rd_en && idx == sel.rd_idx) ? q_r : '0;
  assign tail_tap = (sel.tail_en && idx == sel.tail_idx) ? q_r : '0;

endmodule

// ----- design/plst_sel_tree.sv -----
`timescale 1ns / 1ps

module plst_sel_tree import plst_pkg::*; (
  input  logic  clk,
  input  word_t taps [CAPACITY],
  output word_t sel_q
);

  // At most one tap is nonzero; a registered OR tree collects it.
  // Node j of a level ORs nodes j*TREE_FAN .. j*TREE_FAN+TREE_FAN-1 of the level below.
  word_t node_r   [TREE_LVLS][CAPACITY];
  word_t node_nxt [TREE_LVLS][CAPACITY];

  always_comb begin
    for (int l = 0; l < TREE_LVLS; l++) begin
      for (int j = 0; j < CAPACITY; j++) begin
        node_nxt[l][j] = '0;
      end
    end
    // First level straight from the taps
    for (int j = 0; j < CAPACITY; j++) begin
      for (int k = 0; k < TREE_FAN; k++) begin
        if (j * TREE_FAN + k < CAPACITY) begin
          node_nxt[0][j] = node_nxt[0][j] | taps[j * TREE_FAN + k];
        end
      end
    end
    // Upper levels from the registered level below
    for (int l = 1; l < TREE_LVLS; l++) begin
      for (int j = 0; j < CAPACITY; j++) begin
        for (int k = 0; k < TREE_FAN; k++) begin
          if (j * TREE_FAN + k < CAPACITY) begin
            node_nxt[l][j] = node_nxt[l][j] | node_r[l - 1][j * TREE_FAN + k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < TREE_LVLS; l++) begin
      for (int j = 0; j < CAPACITY; j++) begin
        node_r[l][j] <= node_nxt[l][j];
      end
    end
  end

  assign sel_q = node_r[TREE_LVLS - 1][0];

endmodule
